FILE: rtl/htwd_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
package htwd_pkg;

   // Longest code that a load request may carry.
   localparam int MaxCodeLen = 32;

   // Bits in one compressed data byte.
   localparam int ByteBits = 8;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_DECODE = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_LOAD_ERR,
      ST_DECODE
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [6:0]  symbol;
      logic [5:0]  code_length;
      logic [31:0] code_bits;
      logic [7:0]  data_byte;
      logic [3:0]  valid_bits;
   } req_type;

   typedef struct packed {
      logic [6:0] symbol_out;
      logic       bad_path;
      logic       last;
   } rsp_type;

endpackage

FILE: rtl/htwd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module htwd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/huffman_tree_walk_decoder.sv
// Top level of the Huffman tree-walk decoder: request sequencer around the node memory.
//
//   channel   direction  handshake                 payload
//   req_      in         req_valid / req_stall     req_payload (operation, symbol, code,
//                                                  data byte, valid bit count)
//   rsp_      out        rsp_valid / rsp_stall     rsp_payload (symbol_out, bad_path, last)
//
// A clear request empties the tree to a lone root. A load request walks the code bit
// by bit, then writes the final leaf. An illegal length, and a load that runs out of
// nodes, are answered from the error state. A decode request walks its valid bits one
// by one and gives a result for each leaf reached: every tree step is a dependent read
// of the node memory, and a node just entered is tested first.
// Reset empties the tree to a lone root and returns the walk to the root; the node
// memory itself is not cleared. A stalled result holds the walk only when a new result
// must be produced; a new request is taken once the walk is done.
module huffman_tree_walk_decoder #(
   parameter int NODE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  htwd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output htwd_pkg::rsp_type rsp_payload
);

   import htwd_pkg::*;

   localparam int IW = $clog2(NODE_DEPTH);
   localparam int CW = $clog2(NODE_DEPTH + 1);

   // One tree node: child indexes (zero means absent), leaf mark and symbol.
   typedef struct packed {
      logic [IW-1:0] left;
      logic [IW-1:0] right;
      logic          leaf;
      logic [6:0]    sym;
   } node_type;

   localparam int EW = $bits(node_type);

   // The root lives in flip-flops; memory entry zero is never read.
   state_type     state_ff, state_in;
   logic [IW-1:0] root_left_ff, root_left_in;
   logic [IW-1:0] root_right_ff, root_right_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] walk_ff, walk_in;

   // Load walk.
   logic [IW-1:0] cur_ff, cur_in;
   logic          fresh_ff, fresh_in;
   logic [5:0]    lbits_ff, lbits_in;
   logic [31:0]   code_ff, code_in;
   logic [6:0]    sym_ff, sym_in;

   // Decode walk.
   logic [ByteBits-1:0] data_ff, data_in;
   logic [3:0]          dbits_ff, dbits_in;
   logic                base_root_ff, base_root_in;
   logic                check_ff, check_in;

   // The newest decode result is held back until it is known whether it is the last.
   logic       hold_valid_ff, hold_valid_in;
   logic [6:0] hold_sym_ff, hold_sym_in;
   logic       hold_bad_ff, hold_bad_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic          ram_wr_en;
   logic [IW-1:0] ram_wr_addr;
   node_type      ram_wr_data;
   logic          ram_rd_en;
   logic [IW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;

   htwd_ram #(
      .WIDTH(EW),
      .DEPTH(NODE_DEPTH)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      node_type   rd_entry;
      node_type   root_entry;
      node_type   base;
      node_type   upd;
      logic       out_free;
      logic       produce_ok;
      logic       produce;
      logic [6:0] new_sym;
      logic       new_bad;
      logic       step;
      logic       bit_val;
      logic [5:0] idx;
      logic [IW-1:0] child;

      rd_entry   = node_type'(ram_rd_data);
      root_entry = '{left: root_left_ff, right: root_right_ff, leaf: 1'b0, sym: 7'd0};
      base       = rd_entry;
      upd        = rd_entry;
      out_free   = !rsp_valid_ff || !rsp_stall;
      produce_ok = !hold_valid_ff || out_free;
      produce    = 1'b0;
      new_sym    = 7'd0;
      new_bad    = 1'b0;
      step       = 1'b0;
      bit_val    = 1'b0;
      idx        = 6'd0;
      child      = '0;

      state_in      = state_ff;
      root_left_in  = root_left_ff;
      root_right_in = root_right_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      cur_in        = cur_ff;
      fresh_in      = fresh_ff;
      lbits_in      = lbits_ff;
      code_in       = code_ff;
      sym_in        = sym_ff;
      data_in       = data_ff;
      dbits_in      = dbits_ff;
      base_root_in  = base_root_ff;
      check_in      = check_ff;
      hold_valid_in = hold_valid_ff;
      hold_sym_in   = hold_sym_ff;
      hold_bad_in   = hold_bad_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = walk_ff;

      req_stall = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (op_type'(req_payload.operation))
                  OP_CLEAR: begin
                     root_left_in  = '0;
                     root_right_in = '0;
                     count_in      = CW'(1);
                     walk_in       = '0;
                  end
                  OP_LOAD: begin
                     if (req_payload.code_length == 6'd0 ||
                         {26'd0, req_payload.code_length} > 32'(MaxCodeLen)) begin
                        state_in = ST_LOAD_ERR;
                     end else begin
                        cur_in   = '0;
                        fresh_in = 1'b0;
                        lbits_in = req_payload.code_length;
                        code_in  = req_payload.code_bits;
                        sym_in   = req_payload.symbol;
                        state_in = ST_LOAD;
                     end
                  end
                  OP_DECODE: begin
                     data_in       = req_payload.data_byte;
                     dbits_in      = (req_payload.valid_bits > 4'(ByteBits)) ?
                                     4'(ByteBits) : req_payload.valid_bits;
                     check_in      = 1'b0;
                     hold_valid_in = 1'b0;
                     // A walk left inside the tree is fetched again, since a load may
                     // have given that node new children.
                     if (walk_ff == '0) begin
                        base_root_in = 1'b1;
                     end else begin
                        base_root_in = 1'b0;
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = walk_ff;
                     end
                     state_in = ST_DECODE;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_LOAD_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{symbol_out: 7'd0, bad_path: 1'b1, last: 1'b1};
               state_in     = ST_IDLE;
            end
         end

         ST_LOAD: begin
            // A node created in the previous step is all zeros and is not read back.
            if (cur_ff == '0) begin
               base = root_entry;
            end else if (fresh_ff) begin
               base = '0;
            end else begin
               base = rd_entry;
            end
            if (lbits_ff == 6'd0) begin
               upd         = base;
               upd.leaf    = 1'b1;
               upd.sym     = sym_ff;
               ram_wr_en   = 1'b1;
               ram_wr_addr = cur_ff;
               ram_wr_data = upd;
               state_in    = ST_IDLE;
            end else begin
               idx     = lbits_ff - 6'd1;
               bit_val = idx[5] ? 1'b0 : code_ff[idx[4:0]];
               child   = bit_val ? base.right : base.left;
               if (child != '0) begin
                  cur_in      = child;
                  fresh_in    = 1'b0;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = child;
                  lbits_in    = idx;
               end else if (count_ff == CW'(NODE_DEPTH)) begin
                  // The tree is full. A node made just before stays, so write it empty.
                  if (fresh_ff && cur_ff != '0) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = cur_ff;
                     ram_wr_data = '0;
                  end
                  state_in = ST_LOAD_ERR;
               end else begin
                  upd = base;
                  if (bit_val) begin
                     upd.right = count_ff[IW-1:0];
                  end else begin
                     upd.left = count_ff[IW-1:0];
                  end
                  if (cur_ff == '0) begin
                     root_left_in  = upd.left;
                     root_right_in = upd.right;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = cur_ff;
                     ram_wr_data = upd;
                  end
                  cur_in   = count_ff[IW-1:0];
                  count_in = count_ff + CW'(1);
                  fresh_in = 1'b1;
                  lbits_in = idx;
               end
            end
         end

         ST_DECODE: begin
            if (check_ff) begin
               // The node just entered is in the read register: test its leaf mark.
               if (rd_entry.leaf) begin
                  produce = 1'b1;
                  new_sym = rd_entry.sym;
                  new_bad = 1'b0;
                  if (produce_ok) begin
                     walk_in      = '0;
                     base_root_in = 1'b1;
                     check_in     = 1'b0;
                  end
               end else begin
                  base = rd_entry;
                  step = (dbits_ff != 4'd0);
                  if (!step) begin
                     check_in = 1'b0;
                  end
               end
            end else if (dbits_ff != 4'd0) begin
               step = 1'b1;
               base = base_root_ff ? root_entry : rd_entry;
            end else begin
               // Walk done: the held result, if any, closes the request.
               if (hold_valid_ff) begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in        = '{symbol_out: hold_sym_ff, bad_path: hold_bad_ff,
                                       last: 1'b1};
                     hold_valid_in = 1'b0;
                     state_in      = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end

            if (step) begin
               bit_val = data_ff[ByteBits-1];
               child   = bit_val ? base.right : base.left;
               if (child == '0) begin
                  produce = 1'b1;
                  new_sym = 7'd0;
                  new_bad = 1'b1;
                  if (produce_ok) begin
                     walk_in      = '0;
                     base_root_in = 1'b1;
                     check_in     = 1'b0;
                     data_in      = {data_ff[ByteBits-2:0], 1'b0};
                     dbits_in     = dbits_ff - 4'd1;
                  end
               end else begin
                  walk_in      = child;
                  base_root_in = 1'b0;
                  check_in     = 1'b1;
                  ram_rd_en    = 1'b1;
                  ram_rd_addr  = child;
                  data_in      = {data_ff[ByteBits-2:0], 1'b0};
                  dbits_in     = dbits_ff - 4'd1;
               end
            end

            if (produce && produce_ok) begin
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{symbol_out: hold_sym_ff, bad_path: hold_bad_ff,
                                   last: 1'b0};
               end
               hold_valid_in = 1'b1;
               hold_sym_in   = new_sym;
               hold_bad_in   = new_bad;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         root_left_ff  <= '0;
         root_right_ff <= '0;
         count_ff      <= CW'(1);
         walk_ff       <= '0;
         base_root_ff  <= 1'b1;
         check_ff      <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fresh_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_left_ff  <= root_left_in;
         root_right_ff <= root_right_in;
         count_ff      <= count_in;
         walk_ff       <= walk_in;
         base_root_ff  <= base_root_in;
         check_ff      <= check_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fresh_ff      <= fresh_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      lbits_ff    <= lbits_in;
      code_ff     <= code_in;
      sym_ff      <= sym_in;
      data_ff     <= data_in;
      dbits_ff    <= dbits_in;
      hold_sym_ff <= hold_sym_in;
      hold_bad_ff <= hold_bad_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
